@@ rtl/sfr_pkg.sv @@
// Shared types and constants of the sensor frame receiver.
// Depends on nothing; every other file imports it.
package sfr_pkg;

   localparam int FRAME_LEN_DEFAULT = 11;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] HEADER_BYTE = 8'h55;

   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;
   localparam logic [7:0] TYPE_MAG   = 8'h54;
   localparam logic [7:0] TYPE_GPS   = 8'h57;
   localparam logic [7:0] TYPE_HGT   = 8'h58;
   localparam logic [7:0] TYPE_QUAT  = 8'h59;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM  = 2'd1;
   localparam logic [1:0] STATUS_BAD_TYPE  = 2'd2;

   localparam logic [2:0] KIND_ACCEL = 3'd0;
   localparam logic [2:0] KIND_GYRO  = 3'd1;
   localparam logic [2:0] KIND_ANGLE = 3'd2;
   localparam logic [2:0] KIND_MAG   = 3'd3;
   localparam logic [2:0] KIND_GPS   = 3'd4;
   localparam logic [2:0] KIND_HGT   = 3'd5;
   localparam logic [2:0] KIND_QUAT  = 3'd6;

   localparam logic [3:0] SHORT_LEN = 4'd6;
   localparam logic [3:0] LONG_LEN  = 4'd8;

   // A completed frame as the front end hands it to the back end.
   typedef struct packed {
      logic        sum_bad;
      logic [7:0]  type_byte;
      logic [63:0] raw;
   } frame_type;

endpackage

@@ rtl/sfr_front.sv @@
// Front end: takes one byte a word, checks the header, keeps the running sum
// and pushes each completed frame into the queue. Depends on sfr_pkg.
module sfr_front
   import sfr_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       push_valid,
   input  logic       push_ready,
   output frame_type  push_frame
);

   localparam int CNT_W = $clog2(FRAME_LEN);
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       store_ff [1:FRAME_LEN-2];
   logic             is_last, accept, store_en;

   assign is_last   = (pos_ff == LAST_POS);
   assign req_ready = !is_last || push_ready;
   assign accept    = req_valid && req_ready;
   assign push_valid = req_valid && is_last;

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      store_en = 1'b0;
      if (accept) begin
         priority if (pos_ff == '0 && req_rx_byte != HEADER_BYTE) begin
            pos_in = '0;
            sum_in = '0;
         end else if (!is_last) begin
            pos_in   = pos_ff + 1'b1;
            sum_in   = sum_ff + req_rx_byte;
            store_en = 1'b1;
         end else begin
            pos_in = '0;
            sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   for (genvar i = 1; i <= FRAME_LEN - 2; i++) begin : g_store
      always_ff @(posedge clock) begin
         if (store_en && pos_ff == CNT_W'(i)) begin
            store_ff[i] <= req_rx_byte;
         end
      end
   end

   for (genvar i = 0; i < 8; i++) begin : g_raw
      if (i + 2 <= FRAME_LEN - 2) begin : g_in
         assign push_frame.raw[8*i +: 8] = store_ff[i + 2];
      end else begin : g_out
         assign push_frame.raw[8*i +: 8] = 8'h00;
      end
   end

   assign push_frame.sum_bad   = (sum_ff != req_rx_byte);
   assign push_frame.type_byte = store_ff[1];

endmodule

@@ rtl/sfr_queue.sv @@
// Two-entry queue of completed frames between the front and back ends.
// Depends on sfr_pkg.
module sfr_queue
   import sfr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   output logic      wr_ready,
   input  frame_type wr_frame,
   output logic      rd_valid,
   input  logic      rd_ready,
   output frame_type rd_frame
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   assign wr_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_frame = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_frame;
      end
   end

endmodule

@@ rtl/sfr_back.sv @@
// Back end: decodes the type byte, forms status and payload, and holds the
// result in the output register. Depends on sfr_pkg.
module sfr_back
   import sfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  frame_type   pop_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_status,
   output logic [2:0]  rsp_record_kind,
   output logic [63:0] rsp_payload,
   output logic [3:0]  rsp_payload_bytes
);

   logic        valid_ff, valid_in;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  kind_ff, kind_in;
   logic [63:0] payload_ff, payload_in;
   logic [3:0]  bytes_ff, bytes_in;
   logic        known;
   logic [2:0]  kind_dec;
   logic [3:0]  len_dec;
   logic        load;

   assign load      = pop_valid && (!valid_ff || rsp_ready);
   assign pop_ready = !valid_ff || rsp_ready;

   always_comb begin
      known    = 1'b1;
      kind_dec = KIND_ACCEL;
      len_dec  = SHORT_LEN;
      unique case (pop_frame.type_byte)
         TYPE_ACCEL: begin kind_dec = KIND_ACCEL; len_dec = SHORT_LEN; end
         TYPE_GYRO:  begin kind_dec = KIND_GYRO;  len_dec = SHORT_LEN; end
         TYPE_ANGLE: begin kind_dec = KIND_ANGLE; len_dec = LONG_LEN;  end
         TYPE_MAG:   begin kind_dec = KIND_MAG;   len_dec = SHORT_LEN; end
         TYPE_GPS:   begin kind_dec = KIND_GPS;   len_dec = LONG_LEN;  end
         TYPE_HGT:   begin kind_dec = KIND_HGT;   len_dec = LONG_LEN;  end
         TYPE_QUAT:  begin kind_dec = KIND_QUAT;  len_dec = LONG_LEN;  end
         default:    known = 1'b0;
      endcase
   end

   always_comb begin
      status_in  = STATUS_OK;
      kind_in    = '0;
      payload_in = '0;
      bytes_in   = '0;
      priority if (pop_frame.sum_bad) begin
         status_in = STATUS_CHECKSUM;
      end else if (!known) begin
         status_in = STATUS_BAD_TYPE;
      end else begin
         kind_in  = kind_dec;
         bytes_in = len_dec;
         if (len_dec == SHORT_LEN) begin
            payload_in = {16'h0000, pop_frame.raw[47:0]};
         end else begin
            payload_in = pop_frame.raw;
         end
      end
      valid_in = load || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= status_in;
         kind_ff    <= kind_in;
         payload_ff <= payload_in;
         bytes_ff   <= bytes_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_record_kind   = kind_ff;
   assign rsp_payload       = payload_ff;
   assign rsp_payload_bytes = bytes_ff;

endmodule

@@ rtl/sensor_frame_receiver.sv @@
// A result goes through the frame queue and the output register to rsp_valid.
// Throughput: one word per cycle; a last word waits while the queue is full.
// The two-entry frame queue and the output register let input continue
// while a result waits to be taken.
// Reset clears the byte count, running sum, queue and output valid;
// the frame byte store is not reset.
module sensor_frame_receiver
   import sfr_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_status,
   output logic [2:0]  rsp_record_kind,
   output logic [63:0] rsp_payload,
   output logic [3:0]  rsp_payload_bytes
);

   logic      push_valid, push_ready, pop_valid, pop_ready;
   frame_type push_frame, pop_frame;

   sfr_front #(.FRAME_LEN(FRAME_LEN)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_frame  (push_frame)
   );

   sfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_frame (push_frame),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_frame (pop_frame)
   );

   sfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_frame         (pop_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_payload       (rsp_payload),
      .rsp_payload_bytes (rsp_payload_bytes)
   );

endmodule

@@ rtl/sfr_checker.sv @@
// Port-level assertions for the sensor frame receiver, bound to the top level.
// Depends on sfr_pkg and sensor_frame_receiver.
module sfr_checker
   import sfr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_frame_status,
   input logic [2:0]  rsp_record_kind,
   input logic [63:0] rsp_payload,
   input logic [3:0]  rsp_payload_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload)
         && $stable(rsp_frame_status))
      else $error("A stalled result word changed.");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status != STATUS_OK |->
         rsp_payload == '0 && rsp_payload_bytes == '0 && rsp_record_kind == '0)
      else $error("A rejected frame carried record fields.");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status == STATUS_OK |->
         rsp_payload_bytes == SHORT_LEN || rsp_payload_bytes == LONG_LEN)
      else $error("An accepted record has a wrong payload length.");

   a_short_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_bytes == SHORT_LEN |-> rsp_payload[63:48] == '0)
      else $error("A short record has nonzero upper payload bytes.");

endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_frame_status  (rsp_frame_status),
   .rsp_record_kind   (rsp_record_kind),
   .rsp_payload       (rsp_payload),
   .rsp_payload_bytes (rsp_payload_bytes)
);
